[hdl/flf_pkg.sv]
`timescale 1ns / 1ps

package flf_pkg;

  // Default values of the top-level parameters.
  localparam int MAX_NEIGHBORS_DEF = 256;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int SUM_WIDTH_DEF     = 48;

  // Configuration register map.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 1'd1;
  localparam logic [CFG_DATA_W-1:0] MAX_SPEED_RST = 31'd65536;
  localparam logic [CFG_DATA_W-1:0] RADIUS_RST    = 31'd655360;

  // Item opcodes.
  localparam logic OP_AGENT    = 1'b0;
  localparam logic OP_NEIGHBOR = 1'b1;

  // Input item.
  typedef struct packed {
    logic               opcode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               last;
  } flf_in_t;

  // Result item.
  typedef struct packed {
    logic signed [31:0] sep_x;
    logic signed [31:0] sep_y;
    logic signed [31:0] sep_z;
    logic signed [31:0] align_x;
    logic signed [31:0] align_y;
    logic signed [31:0] align_z;
    logic signed [31:0] coh_x;
    logic signed [31:0] coh_y;
    logic signed [31:0] coh_z;
    logic [8:0]         in_range_count;
    logic               overflow;
  } flf_out_t;

  // Operation of the shared iterative unit.
  typedef enum logic {
    ITER_DIV,
    ITER_SQRT
  } flf_iter_mode_e;

  typedef struct packed {
    logic           start;
    flf_iter_mode_e mode;
  } flf_iter_cmd_t;

endpackage

[hdl/flf_stream_if.sv]
`timescale 1ns / 1ps

// Valid/ready channel; one transfer when valid and ready are both high.
interface flf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/flf_mul.sv]
`timescale 1ns / 1ps

// Shared 32x32 unsigned multiplier with a registered product.
module flf_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

[hdl/flf_iter.sv]
`timescale 1ns / 1ps

// Iterative unit: restoring divide (one quotient bit per cycle) or
// integer square root (one root bit per cycle).
module flf_iter #(
  parameter int NUM_W = 64,
  parameter int QW    = 33
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  flf_pkg::flf_iter_cmd_t cmd_i,
  input  logic [NUM_W-1:0]       dividend_i,
  input  logic [63:0]            divisor_i,
  output logic                   done_o,
  output logic [QW-1:0]          result_o
);
  import flf_pkg::*;

  localparam int STEP_W = $clog2(QW + 1);

  logic              busy_q;
  logic              done_q;
  flf_iter_mode_e    mode_q;
  logic [STEP_W-1:0] cnt_q;
  logic [63:0]       rem_q;
  logic [QW-1:0]     lo_q;
  logic [63:0]       dvs_q;
  logic [QW-1:0]     quo_q;
  logic [63:0]       root_q;
  logic [63:0]       bit_q;

  logic [64:0] div_t;
  logic        div_ge;
  logic [64:0] div_sub;
  logic [64:0] sq_t;
  logic        sq_ge;
  logic [64:0] sq_sub;

  // One divide step: shift in the next dividend bit and try the subtract.
  assign div_t   = {rem_q, lo_q[QW-1]};
  assign div_ge  = div_t >= {1'b0, dvs_q};
  assign div_sub = div_t - {1'b0, dvs_q};

  // One square-root step.
  assign sq_t   = {1'b0, root_q} + {1'b0, bit_q};
  assign sq_ge  = {1'b0, rem_q} >= sq_t;
  assign sq_sub = {1'b0, rem_q} - sq_t;

  // Control: step count and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mode_q <= ITER_DIV;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        mode_q <= cmd_i.mode;
        cnt_q  <= (cmd_i.mode == ITER_SQRT) ? STEP_W'(32) : STEP_W'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath. The upper dividend bits seed the remainder, which is valid
  // because the quotient is known to fit in QW bits.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rem_q  <= (cmd_i.mode == ITER_SQRT) ? dividend_i[63:0] : 64'(dividend_i >> QW);
      lo_q   <= dividend_i[QW-1:0];
      dvs_q  <= divisor_i;
      quo_q  <= '0;
      root_q <= '0;
      bit_q  <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (mode_q == ITER_DIV) begin
        rem_q <= div_ge ? div_sub[63:0] : div_t[63:0];
        quo_q <= {quo_q[QW-2:0], div_ge};
        lo_q  <= {lo_q[QW-2:0], 1'b0};
      end else begin
        if (sq_ge) begin
          rem_q  <= sq_sub[63:0];
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = (mode_q == ITER_SQRT) ? QW'(root_q[31:0]) : quo_q;

endmodule

[hdl/flocking_forces.sv]
`timescale 1ns / 1ps

// Boids flocking forces in signed fixed point. An agent item loads the agent
// and clears the sums; each neighbor item within the radius adds its velocity,
// position and a separation term diff/d^2; an item marked last produces one
// result with separation, alignment and cohesion steering. One item is worked
// at a time under a sequencer that drives a shared 32x32 multiplier and a
// shared bit-serial divide/square-root unit with QW = max(33, 2*FRAC_BITS+1)
// quotient bits. A neighbor inside the radius runs the three separation
// divides (none when d^2 is zero); a last item runs the averages and, where
// a steering vector exceeds the speed cap, its length and limiting divides.
// The input is ready only while the block is idle; a result waits in an
// output register, and the next result is held back until it has been taken.
module flocking_forces #(
  parameter int MAX_NEIGHBORS = flf_pkg::MAX_NEIGHBORS_DEF,
  parameter int FRAC_BITS     = flf_pkg::FRAC_BITS_DEF,
  parameter int SUM_WIDTH     = flf_pkg::SUM_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [flf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [flf_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  flf_stream_if.sink                       in_i,
  flf_stream_if.source                     out_o
);
  import flf_pkg::*;

  localparam int QW    = (2 * FRAC_BITS + 1 > 33) ? 2 * FRAC_BITS + 1 : 33;
  localparam int NUM_W = (31 + 2 * FRAC_BITS > 64) ? 31 + 2 * FRAC_BITS : 64;
  localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
  localparam int ADD_W = QW + 1;
  localparam int EXT_W = ((SUM_WIDTH > ADD_W) ? SUM_WIDTH : ADD_W) + 1;
  localparam int SAT_W = (SUM_WIDTH > 36) ? SUM_WIDTH : 36;

  localparam logic signed [EXT_W-1:0] SUM_HI =
    {{(EXT_W - SUM_WIDTH + 1){1'b0}}, {(SUM_WIDTH - 1){1'b1}}};
  localparam logic signed [EXT_W-1:0] SUM_LO =
    {{(EXT_W - SUM_WIDTH + 1){1'b1}}, {(SUM_WIDTH - 1){1'b0}}};
  localparam logic signed [SAT_W-1:0] S32_HI = {{(SAT_W - 31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SAT_W-1:0] S32_LO = {{(SAT_W - 31){1'b1}}, {31{1'b0}}};

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIFF, ST_SQ_MUL, ST_SQ_ACC, ST_RR_MUL, ST_RR_CMP, ST_SUM_ADD,
    ST_SEP_DIV, ST_SEP_WAIT, ST_FIN, ST_AVG_DIV, ST_AVG_WAIT, ST_FLAGS,
    ST_MM_MUL, ST_MM_CMP, ST_SQRT, ST_SQRT_WAIT, ST_LIM_MUL, ST_LIM_DIV,
    ST_LIM_WAIT, ST_STEER, ST_OUT
  } state_e;

  // Saturating accumulate at the sum width.
  function automatic logic signed [SUM_WIDTH-1:0] sat_add(
    input logic signed [SUM_WIDTH-1:0] acc,
    input logic signed [EXT_W-1:0]     x
  );
    logic signed [EXT_W-1:0] s;
    s = EXT_W'(acc) + x;
    if (s > SUM_HI) begin
      return SUM_HI[SUM_WIDTH-1:0];
    end else if (s < SUM_LO) begin
      return SUM_LO[SUM_WIDTH-1:0];
    end
    return s[SUM_WIDTH-1:0];
  endfunction

  // Saturate to a signed 32-bit output.
  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    if (v > S32_HI) begin
      return 32'sh7FFF_FFFF;
    end else if (v < S32_LO) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  state_e                      state_q;
  logic [CFG_DATA_W-1:0]       max_speed_q;
  logic [CFG_DATA_W-1:0]       radius_q;
  flf_in_t                     item_q;
  logic signed [31:0]          pos_q [3];
  logic signed [31:0]          vel_q [3];
  logic signed [SUM_WIDTH-1:0] sep_q [3];
  logic signed [SUM_WIDTH-1:0] vsum_q [3];
  logic signed [SUM_WIDTH-1:0] psum_q [3];
  logic [CNT_W-1:0]            match_q;
  logic [CNT_W-1:0]            seen_q;
  logic                        ovf_q;
  logic [32:0]                 a_q [3];
  logic                        neg_q [3];
  logic [63:0]                 d2_q;
  logic [32:0]                 len_q;
  logic [32:0]                 lim_q;
  logic [2:0]                  cidx_q;
  logic                        vec_q;
  logic                        far_q;
  logic                        big_q;
  logic                        over_q;
  logic                        in_res_q;
  logic signed [31:0]          res_q [6];
  flf_out_t                    out_q;
  logic                        out_valid_q;

  logic signed [31:0]          in_pos [3];
  logic signed [31:0]          in_vel [3];
  logic [1:0]                  c;
  logic [1:0]                  sum_sel;
  logic signed [32:0]          diff;
  logic [32:0]                 diff_mag;
  logic signed [SUM_WIDTH-1:0] sum_v;
  logic                        sum_neg;
  logic [SUM_WIDTH-1:0]        sum_mag;
  logic signed [34:0]          avg;
  logic signed [34:0]          w;
  logic [34:0]                 w_mag;
  logic signed [ADD_W-1:0]     sep_term;
  logic [32:0]                 steer_mag;
  logic signed [34:0]          steer_d;
  logic signed [35:0]          steer_diff;
  logic [2:0]                  res_idx;
  logic                        over_any;
  logic                        big_any;
  logic [CNT_W+8:0]            cnt_ext;

  logic [31:0]                 mul_a;
  logic [31:0]                 mul_b;
  logic [63:0]                 mul_p;
  flf_iter_cmd_t               iter_cmd;
  logic [NUM_W-1:0]            iter_dividend;
  logic [63:0]                 iter_divisor;
  logic                        iter_done;
  logic [QW-1:0]               iter_res;

  assign in_pos[0] = item_q.pos_x;
  assign in_pos[1] = item_q.pos_y;
  assign in_pos[2] = item_q.pos_z;
  assign in_vel[0] = item_q.vel_x;
  assign in_vel[1] = item_q.vel_y;
  assign in_vel[2] = item_q.vel_z;

  // Component selects and per-step arithmetic.
  assign c       = cidx_q[1:0];
  assign sum_sel = (cidx_q >= 3'd3) ? 2'(cidx_q - 3'd3) : cidx_q[1:0];
  assign diff     = 33'(pos_q[c]) - 33'(in_pos[c]);
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

  assign sum_v   = vec_q ? psum_q[c] : vsum_q[c];
  assign sum_neg = sum_v[SUM_WIDTH-1];
  assign sum_mag = sum_neg ? SUM_WIDTH'(-sum_v) : SUM_WIDTH'(sum_v);

  always_comb begin
    avg = 35'({2'b00, iter_res[32:0]});
    if (sum_neg) begin
      avg = -avg;
    end
    w = vec_q ? (avg - 35'(pos_q[c])) : avg;
    w_mag = w[34] ? 35'(-w) : 35'(w);
  end

  assign sep_term = neg_q[c] ? ADD_W'(-{1'b0, iter_res}) : ADD_W'({1'b0, iter_res});

  always_comb begin
    steer_mag = over_q ? lim_q : a_q[c];
    steer_d   = 35'({2'b00, steer_mag});
    if (neg_q[c]) begin
      steer_d = -steer_d;
    end
    steer_diff = 36'(steer_d) - 36'(vel_q[c]);
  end

  assign res_idx = vec_q ? (3'(c) + 3'd3) : 3'(c);

  assign over_any = (a_q[0] > {2'b00, max_speed_q}) || (a_q[1] > {2'b00, max_speed_q}) ||
                    (a_q[2] > {2'b00, max_speed_q});
  assign big_any  = (a_q[0][32:31] != 2'b00) || (a_q[1][32:31] != 2'b00) ||
                    (a_q[2][32:31] != 2'b00);

  assign cnt_ext = (CNT_W + 9)'(match_q);

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ_MUL: begin
        mul_a = big_q ? a_q[c][32:1] : a_q[c][31:0];
        mul_b = mul_a;
      end
      ST_RR_MUL: begin
        mul_a = {1'b0, radius_q};
        mul_b = {1'b0, radius_q};
      end
      ST_MM_MUL: begin
        mul_a = {1'b0, max_speed_q};
        mul_b = {1'b0, max_speed_q};
      end
      ST_LIM_MUL: begin
        mul_a = a_q[c][31:0];
        mul_b = {1'b0, max_speed_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Iterative unit command and operands.
  always_comb begin
    iter_cmd.start = 1'b0;
    iter_cmd.mode  = ITER_DIV;
    iter_dividend  = '0;
    iter_divisor   = '0;
    case (state_q)
      ST_SEP_DIV: begin
        iter_cmd.start = 1'b1;
        iter_dividend  = NUM_W'({a_q[c][30:0], {(2 * FRAC_BITS){1'b0}}});
        iter_divisor   = d2_q;
      end
      ST_AVG_DIV: begin
        iter_cmd.start = 1'b1;
        iter_dividend  = NUM_W'(sum_mag);
        iter_divisor   = 64'(match_q);
      end
      ST_SQRT: begin
        iter_cmd.start = 1'b1;
        iter_cmd.mode  = ITER_SQRT;
        iter_dividend  = NUM_W'(d2_q);
      end
      ST_LIM_DIV: begin
        iter_cmd.start = 1'b1;
        iter_dividend  = NUM_W'(mul_p);
        iter_divisor   = 64'(len_q);
      end
      default: begin
        iter_cmd.start = 1'b0;
      end
    endcase
  end

  flf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  flf_iter #(
    .NUM_W (NUM_W),
    .QW    (QW)
  ) u_iter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (iter_cmd),
    .dividend_i (iter_dividend),
    .divisor_i  (iter_divisor),
    .done_o     (iter_done),
    .result_o   (iter_res)
  );

  // Sequencer, accumulators, configuration and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      max_speed_q <= MAX_SPEED_RST;
      radius_q    <= RADIUS_RST;
      for (int k = 0; k < 3; k++) begin
        pos_q[k]  <= '0;
        vel_q[k]  <= '0;
        sep_q[k]  <= '0;
        vsum_q[k] <= '0;
        psum_q[k] <= '0;
      end
      match_q     <= '0;
      seen_q      <= '0;
      ovf_q       <= 1'b0;
      cidx_q      <= '0;
      vec_q       <= 1'b0;
      far_q       <= 1'b0;
      big_q       <= 1'b0;
      over_q      <= 1'b0;
      in_res_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_SPEED: max_speed_q <= cfg_wdata_i;
          CFG_RADIUS:    radius_q    <= cfg_wdata_i;
          default:       radius_q    <= radius_q;
        endcase
      end

      // A taken result frees the output register unless a new one loads now.
      if (out_valid_q && out_o.ready && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            item_q <= in_i.data;
            if (in_i.data.opcode == OP_AGENT) begin
              pos_q[0] <= in_i.data.pos_x;
              pos_q[1] <= in_i.data.pos_y;
              pos_q[2] <= in_i.data.pos_z;
              vel_q[0] <= in_i.data.vel_x;
              vel_q[1] <= in_i.data.vel_y;
              vel_q[2] <= in_i.data.vel_z;
              for (int k = 0; k < 3; k++) begin
                sep_q[k]  <= '0;
                vsum_q[k] <= '0;
                psum_q[k] <= '0;
              end
              match_q <= '0;
              seen_q  <= '0;
              ovf_q   <= 1'b0;
              state_q <= ST_FIN;
            end else if (seen_q >= CNT_W'(MAX_NEIGHBORS)) begin
              ovf_q   <= 1'b1;
              state_q <= ST_FIN;
            end else begin
              seen_q  <= seen_q + CNT_W'(1);
              cidx_q  <= '0;
              far_q   <= 1'b0;
              state_q <= ST_DIFF;
            end
          end
        end

        // Component differences and the per-axis radius test.
        ST_DIFF: begin
          a_q[c]   <= diff_mag;
          neg_q[c] <= diff[32];
          if (diff_mag >= {2'b00, radius_q}) begin
            far_q <= 1'b1;
          end
          if (c == 2'd2) begin
            cidx_q <= '0;
            d2_q   <= '0;
            big_q  <= 1'b0;
            if (far_q || (diff_mag >= {2'b00, radius_q})) begin
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_SQ_MUL;
            end
          end else begin
            cidx_q <= cidx_q + 3'd1;
          end
        end

        // Sum of squares, for d^2 or the steering vector length.
        ST_SQ_MUL: begin
          state_q <= ST_SQ_ACC;
        end

        ST_SQ_ACC: begin
          d2_q <= d2_q + mul_p;
          if (c == 2'd2) begin
            cidx_q  <= '0;
            state_q <= in_res_q ? ST_MM_MUL : ST_RR_MUL;
          end else begin
            cidx_q  <= cidx_q + 3'd1;
            state_q <= ST_SQ_MUL;
          end
        end

        ST_RR_MUL: begin
          state_q <= ST_RR_CMP;
        end

        ST_RR_CMP: begin
          cidx_q <= '0;
          if (d2_q < mul_p) begin
            match_q <= match_q + CNT_W'(1);
            state_q <= ST_SUM_ADD;
          end else begin
            state_q <= ST_FIN;
          end
        end

        // Velocity sums first, then position sums, one per cycle.
        ST_SUM_ADD: begin
          if (cidx_q < 3'd3) begin
            vsum_q[sum_sel] <= sat_add(vsum_q[sum_sel], EXT_W'(in_vel[sum_sel]));
          end else begin
            psum_q[sum_sel] <= sat_add(psum_q[sum_sel], EXT_W'(in_pos[sum_sel]));
          end
          if (cidx_q == 3'd5) begin
            cidx_q  <= '0;
            state_q <= (d2_q != 64'd0) ? ST_SEP_DIV : ST_FIN;
          end else begin
            cidx_q <= cidx_q + 3'd1;
          end
        end

        ST_SEP_DIV: begin
          state_q <= ST_SEP_WAIT;
        end

        ST_SEP_WAIT: begin
          if (iter_done) begin
            sep_q[c] <= sat_add(sep_q[c], EXT_W'(sep_term));
            if (c == 2'd2) begin
              state_q <= ST_FIN;
            end else begin
              cidx_q  <= cidx_q + 3'd1;
              state_q <= ST_SEP_DIV;
            end
          end
        end

        // End of an item: start the result when it is marked last.
        ST_FIN: begin
          if (item_q.last) begin
            in_res_q <= 1'b1;
            vec_q    <= 1'b0;
            cidx_q   <= '0;
            if (match_q == '0) begin
              for (int k = 0; k < 6; k++) begin
                res_q[k] <= '0;
              end
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_AVG_DIV;
            end
          end else begin
            state_q <= ST_IDLE;
          end
        end

        // Averages, and the cohesion offset from the agent.
        ST_AVG_DIV: begin
          state_q <= ST_AVG_WAIT;
        end

        ST_AVG_WAIT: begin
          if (iter_done) begin
            a_q[c]   <= w_mag[32:0];
            neg_q[c] <= w[34];
            if (c == 2'd2) begin
              state_q <= ST_FLAGS;
            end else begin
              cidx_q  <= cidx_q + 3'd1;
              state_q <= ST_AVG_DIV;
            end
          end
        end

        ST_FLAGS: begin
          over_q  <= over_any;
          big_q   <= big_any;
          cidx_q  <= '0;
          d2_q    <= '0;
          state_q <= ST_SQ_MUL;
        end

        ST_MM_MUL: begin
          state_q <= ST_MM_CMP;
        end

        ST_MM_CMP: begin
          cidx_q <= '0;
          if (over_q || (d2_q > mul_p)) begin
            over_q  <= 1'b1;
            state_q <= ST_SQRT;
          end else begin
            state_q <= ST_STEER;
          end
        end

        ST_SQRT: begin
          state_q <= ST_SQRT_WAIT;
        end

        ST_SQRT_WAIT: begin
          if (iter_done) begin
            len_q   <= big_q ? {iter_res[31:0], 1'b0} : {1'b0, iter_res[31:0]};
            state_q <= ST_LIM_MUL;
          end
        end

        ST_LIM_MUL: begin
          state_q <= ST_LIM_DIV;
        end

        ST_LIM_DIV: begin
          state_q <= ST_LIM_WAIT;
        end

        ST_LIM_WAIT: begin
          if (iter_done) begin
            lim_q   <= (len_q == '0) ? '0 : iter_res[32:0];
            state_q <= ST_STEER;
          end
        end

        // Desired minus current velocity, saturated.
        ST_STEER: begin
          res_q[res_idx] <= sat32(SAT_W'(steer_diff));
          if (c == 2'd2) begin
            cidx_q <= '0;
            if (!vec_q) begin
              vec_q   <= 1'b1;
              state_q <= ST_AVG_DIV;
            end else begin
              state_q <= ST_OUT;
            end
          end else begin
            cidx_q  <= cidx_q + 3'd1;
            state_q <= over_q ? ST_LIM_MUL : ST_STEER;
          end
        end

        // Load the output register once the previous result has gone.
        ST_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_q.sep_x          <= sat32(SAT_W'(sep_q[0]));
            out_q.sep_y          <= sat32(SAT_W'(sep_q[1]));
            out_q.sep_z          <= sat32(SAT_W'(sep_q[2]));
            out_q.align_x        <= res_q[0];
            out_q.align_y        <= res_q[1];
            out_q.align_z        <= res_q[2];
            out_q.coh_x          <= res_q[3];
            out_q.coh_y          <= res_q[4];
            out_q.coh_z          <= res_q[5];
            out_q.in_range_count <= cnt_ext[8:0];
            out_q.overflow       <= ovf_q;
            out_valid_q          <= 1'b1;
            in_res_q             <= 1'b0;
            state_q              <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import flf_pkg::*;

  localparam longint CYCLE_LIMIT = 6000000;
  localparam int     DRAIN_CYCLES = 500;

  // Scoreboard with its own flocking-force predictor and a store of forces still due.
  class flock_scoreboard;
    longint          apos[3], avel[3], sep_acc[3], vel_acc[3], pos_acc[3];
    int unsigned     match_n, seen_n;
    bit              ovf;
    longint unsigned speed_cap, radius;
    flf_out_t        forces_due[$];
    int              errors;

    function new();
      speed_cap = MAX_SPEED_RST;
      radius    = RADIUS_RST;
      for (int c = 0; c < 3; c++) begin
        apos[c] = 0; avel[c] = 0; sep_acc[c] = 0; vel_acc[c] = 0; pos_acc[c] = 0;
      end
      match_n = 0; seen_n = 0; ovf = 0; errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_MAX_SPEED) speed_cap = val;
      else radius = val;
    endfunction

    function longint acc_add(longint a, longint b);
      longint hi, lo;
      hi = (longint'(1) <<< (SUM_WIDTH_DEF - 1)) - 1;
      lo = -hi - 1;
      if (b > 0 && a > hi - b) return hi;
      if (b < 0 && a < lo - b) return lo;
      return a + b;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned abs64(longint v);
      return v < 0 ? longint'(0) - v : v;
    endfunction

    function longint unsigned root_floor(longint unsigned n);
      longint unsigned r, t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (longint'(1) << b);
        if (t * t <= n) r = t;
      end
      return r;
    endfunction

    // Limit the desired vector to the speed cap, then subtract the agent velocity.
    function void steer_to(input longint want[3], output longint o[3]);
      longint unsigned a[3], l2, s2, len, q;
      bit big, over;
      int e;
      longint d;
      big = 0; over = 0; l2 = 0; s2 = 0;
      for (int c = 0; c < 3; c++) begin
        a[c] = abs64(want[c]);
        if (a[c] > speed_cap) over = 1;
        if (a[c] >= 64'h8000_0000) big = 1;
      end
      if (!over) begin
        for (int c = 0; c < 3; c++) l2 += a[c] * a[c];
        over = l2 > speed_cap * speed_cap;
      end
      e = big ? 1 : 0;
      for (int c = 0; c < 3; c++) s2 += (a[c] >> e) * (a[c] >> e);
      len = root_floor(s2) << e;
      for (int c = 0; c < 3; c++) begin
        d = want[c];
        if (over) begin
          d = 0;
          if (len != 0) begin
            q = (a[c] * speed_cap) / len;
            d = want[c] < 0 ? -longint'(q) : longint'(q);
          end
        end
        o[c] = clip32(d - avel[c]);
      end
    endfunction

    // Note an accepted item: update the flock state and queue forces when last is set.
    function void note_item(flf_in_t it);
      longint p[3], v[3], diff[3], w[3], al[3], co[3];
      longint unsigned a[3], d2, q;
      bit hit;
      flf_out_t r;
      p[0] = longint'(it.pos_x); p[1] = longint'(it.pos_y); p[2] = longint'(it.pos_z);
      v[0] = longint'(it.vel_x); v[1] = longint'(it.vel_y); v[2] = longint'(it.vel_z);
      if (it.opcode == OP_AGENT) begin
        for (int c = 0; c < 3; c++) begin
          apos[c] = p[c]; avel[c] = v[c];
          sep_acc[c] = 0; vel_acc[c] = 0; pos_acc[c] = 0;
        end
        match_n = 0; seen_n = 0; ovf = 0;
      end else if (seen_n >= MAX_NEIGHBORS_DEF) begin
        ovf = 1;
      end else begin
        seen_n++;
        hit = 1; d2 = 0;
        for (int c = 0; c < 3; c++) begin
          diff[c] = apos[c] - p[c];
          a[c] = abs64(diff[c]);
          if (a[c] >= radius) hit = 0;
        end
        if (hit) begin
          for (int c = 0; c < 3; c++) d2 += a[c] * a[c];
          hit = d2 < radius * radius;
        end
        if (hit) begin
          match_n++;
          for (int c = 0; c < 3; c++) begin
            vel_acc[c] = acc_add(vel_acc[c], v[c]);
            pos_acc[c] = acc_add(pos_acc[c], p[c]);
            if (d2 != 0) begin
              q = (a[c] << (2 * FRAC_BITS_DEF)) / d2;
              sep_acc[c] = acc_add(sep_acc[c], diff[c] < 0 ? -longint'(q) : longint'(q));
            end
          end
        end
      end
      if (!it.last) return;
      for (int c = 0; c < 3; c++) begin al[c] = 0; co[c] = 0; end
      if (match_n != 0) begin
        for (int c = 0; c < 3; c++) w[c] = vel_acc[c] / longint'(match_n);
        steer_to(w, al);
        for (int c = 0; c < 3; c++) w[c] = pos_acc[c] / longint'(match_n) - apos[c];
        steer_to(w, co);
      end
      r.sep_x = 32'(clip32(sep_acc[0]));
      r.sep_y = 32'(clip32(sep_acc[1]));
      r.sep_z = 32'(clip32(sep_acc[2]));
      r.align_x = 32'(al[0]); r.align_y = 32'(al[1]); r.align_z = 32'(al[2]);
      r.coh_x = 32'(co[0]); r.coh_y = 32'(co[1]); r.coh_z = 32'(co[2]);
      r.in_range_count = match_n[8:0];
      r.overflow = ovf;
      forces_due.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    endtask

    task check_result(flf_out_t got);
      flf_out_t w;
      if (forces_due.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      w = forces_due.pop_front();
      if (got.sep_x !== w.sep_x) report("sep_x", got.sep_x, w.sep_x);
      if (got.sep_y !== w.sep_y) report("sep_y", got.sep_y, w.sep_y);
      if (got.sep_z !== w.sep_z) report("sep_z", got.sep_z, w.sep_z);
      if (got.align_x !== w.align_x) report("align_x", got.align_x, w.align_x);
      if (got.align_y !== w.align_y) report("align_y", got.align_y, w.align_y);
      if (got.align_z !== w.align_z) report("align_z", got.align_z, w.align_z);
      if (got.coh_x !== w.coh_x) report("coh_x", got.coh_x, w.coh_x);
      if (got.coh_y !== w.coh_y) report("coh_y", got.coh_y, w.coh_y);
      if (got.coh_z !== w.coh_z) report("coh_z", got.coh_z, w.coh_z);
      if (got.in_range_count !== w.in_range_count)
        report("in_range_count", got.in_range_count, w.in_range_count);
      if (got.overflow !== w.overflow) report("overflow", got.overflow, w.overflow);
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    calm;
  longint                cycles;
  flock_scoreboard       sb;
  flf_in_t               agent_now;

  flf_stream_if #(.payload_t(flf_in_t))  in_if ();
  flf_stream_if #(.payload_t(flf_out_t)) out_if ();

  flocking_forces i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Clock and cycle limit.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result side: check each transfer and stall in random bursts.
  initial begin
    int stall;
    stall = 0;
    out_if.ready = 0;
    wait (sb != null);
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.data);
      if (stall > 0) begin
        stall--;
        out_if.ready <= 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 4) - 1;
        out_if.ready <= 0;
      end else begin
        out_if.ready <= 1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1; cfg_idx <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
  endtask

  // Offer one item and hold it until the transfer; sometimes idle afterward.
  task automatic send_item(flf_in_t it);
    in_if.valid <= 1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    sb.note_item(it);
    if (it.opcode == OP_AGENT) agent_now = it;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Stop offering items, then wait until every result is in and the block has settled.
  task automatic settle();
    in_if.valid <= 0;
    while (sb.forces_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic flf_in_t make_item(logic op, logic lst);
    flf_in_t it;
    it.opcode = op; it.last = lst;
    it.pos_x = pick_word(); it.pos_y = pick_word(); it.pos_z = pick_word();
    it.vel_x = pick_word(); it.vel_y = pick_word(); it.vel_z = pick_word();
    return it;
  endfunction

  // A neighbor placed around the current agent, mostly inside the radius.
  function automatic flf_in_t near_neighbor(logic lst);
    flf_in_t it;
    longint span, off[3];
    it = make_item(OP_NEIGHBOR, lst);
    span = longint'(sb.radius) + longint'(sb.radius) / 4 + 2;
    for (int c = 0; c < 3; c++) begin
      off[c] = longint'($urandom) % span;
      off[c] = off[c] / longint'($urandom_range(1, 3));
      if ($urandom_range(0, 1)) off[c] = -off[c];
    end
    if ($urandom_range(0, 15) == 0) begin
      off[0] = 0; off[1] = 0; off[2] = 0;
    end
    it.pos_x = agent_now.pos_x + 32'(off[0]);
    it.pos_y = agent_now.pos_y + 32'(off[1]);
    it.pos_z = agent_now.pos_z + 32'(off[2]);
    return it;
  endfunction

  // One flock list: an agent, its neighbors, last on the final one; some noise.
  task automatic send_list(int n, ref int count);
    flf_in_t it;
    it = make_item(OP_AGENT, n == 0 && $urandom_range(0, 1));
    send_item(it);
    count++;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) it = make_item(OP_NEIGHBOR, $urandom_range(0, 1));
      else it = near_neighbor(k == n - 1 || $urandom_range(0, 15) == 0);
      send_item(it);
      count++;
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] speeds[6], radii[6];
    flf_in_t it;
    int count;
    sb = new();
    calm = 0;
    rst_n = 0;
    cfg_we = 0; cfg_idx = CFG_MAX_SPEED; cfg_wdata = '0;
    in_if.valid = 0;
    in_if.data = '0;
    agent_now = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: coincident neighbor, last on an agent, extremes of every field.
    it = '0; it.opcode = OP_AGENT; it.last = 1; send_item(it);
    it = '0; it.opcode = OP_NEIGHBOR; it.last = 1; it.vel_x = 32'h0003_0000; send_item(it);
    it = '0; it.opcode = OP_NEIGHBOR; it.pos_x = 32'h0001_0000; it.vel_y = 32'h7FFF_FFFF;
    send_item(it);
    it = '0; it.opcode = OP_NEIGHBOR; it.pos_y = -32'sh0000_8000; it.vel_z = 32'h8000_0000;
    it.last = 1; send_item(it);
    it = '0; it.opcode = OP_NEIGHBOR; it.pos_x = 32'h7FFF_FFFF; it.last = 1; send_item(it);
    it = '0; it.opcode = OP_NEIGHBOR; it.pos_z = 32'h0000_0001; it.last = 1; send_item(it);
    it = '0; it.opcode = OP_NEIGHBOR; it.pos_x = 32'h0009_FFFF; it.last = 1; send_item(it);
    it = '0; it.opcode = OP_AGENT; it.pos_x = 32'h8000_0000; it.pos_y = 32'h8000_0000;
    it.pos_z = 32'h8000_0000; it.vel_x = 32'h7FFF_FFFF; it.vel_y = 32'h8000_0000;
    send_item(it);
    it.opcode = OP_NEIGHBOR; it.pos_x = 32'h8000_0001; it.vel_x = 32'h8000_0000;
    it.vel_y = 32'h7FFF_FFFF; it.vel_z = 32'hFFFF_FFFF; it.last = 1; send_item(it);
    it = '1; it.opcode = OP_AGENT; it.last = 0; send_item(it);
    it = '1; it.last = 1; send_item(it);
    for (int k = 0; k < 10; k++) send_item(near_neighbor(k[0]));
    settle();

    // Random phases under several register settings, the extremes among them.
    speeds[0] = 31'd0;          radii[0] = 31'h7FFF_FFFF;
    speeds[1] = 31'h7FFF_FFFF;  radii[1] = 31'h7FFF_FFFF;
    speeds[2] = 31'd327680;     radii[2] = 31'd0;
    speeds[3] = $urandom;       radii[3] = $urandom_range(1, 31'h0100_0000);
    speeds[4] = 31'd1;          radii[4] = 31'd1310720;
    speeds[5] = MAX_SPEED_RST;  radii[5] = RADIUS_RST;
    count = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_MAX_SPEED, speeds[ph]);
      write_reg(CFG_RADIUS, radii[ph]);
      if (ph == 2) begin
        // More neighbors than the block keeps, to raise the overflow flag.
        send_list(270, count);
        it = near_neighbor(1); send_item(it);
      end
      if (ph == 5) calm = 0;
      while (count < (ph + 1) * 310) begin
        if (ph == 5 && count > 5 * 310 + 120) calm = 1;
        send_list($urandom_range(0, 12), count);
      end
      settle();
    end
    in_if.valid <= 0;
    settle();

    if (sb.errors == 0 && sb.forces_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
